// File: rtl/core/gce_pkg.sv
// ----------------------------------------------------------------------------
// gce_pkg
// shared types and constants of the gamepad change event generator
// ----------------------------------------------------------------------------
package gce_pkg;

	// report field widths
	localparam int PAD_W     = 2;
	localparam int PACKET_W  = 32;
	localparam int BUTTON_W  = 16;
	localparam int TRIGGER_W = 8;
	localparam int AXIS_W    = 16;
	localparam int KIND_W    = 3;

	// pending events: presses, releases, then four analog changes
	localparam int PEND_W    = 2 * BUTTON_W + 4;
	localparam int PEND_LTRIG = 2 * BUTTON_W;
	localparam int PEND_RTRIG = 2 * BUTTON_W + 1;
	localparam int PEND_LSTK  = 2 * BUTTON_W + 2;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 56;

	// event kind codes
	localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LTRIG   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RTRIG   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LSTICK  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RSTICK  = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// stored report of one pad
	typedef struct packed {
		logic [PACKET_W-1:0]  packet;
		logic [BUTTON_W-1:0]  buttons;
		logic [2*TRIGGER_W-1:0] triggers;
		logic [2*AXIS_W-1:0]  left_stick;
		logic [2*AXIS_W-1:0]  right_stick;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic check;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic fresh;
		logic any_event;
		logic final_event;
		logic out_free;
	} status_t;

endpackage

// File: rtl/core/gamepad_change_event_generator.sv
// ----------------------------------------------------------------------------
// gamepad_change_event_generator
// turns polled controller reports into button and analog change events
// ----------------------------------------------------------------------------
//
// channel  dir  fields (tdata from bit 0 up)                               sideband
// s_axis   in   pad, packet_number, buttons, left_trigger, right_trigger,
//               left_x, left_y, right_x, right_y (130 bits, padded to 136)  -
// m_axis   out  event_pad, button_mask, value_first, value_second
//               (50 bits, padded to 56)                                     tuser=event_kind,
//                                                                           tlast=last
//
// a report is accepted, then checked against the stored report of its pad,
// then its events follow (up to 20); the pending event mask sets the count,
// the single output register gives one event per cycle while m_axis does not stall
// stale reports and pads beyond PAD_COUNT are checked but give no events
// arst_n clears the stored state of every pad to zero at once
// a stalled m_axis holds the sequencer; the next report is accepted while the
// last event of the previous one still waits in the output register
//
module gamepad_change_event_generator #(
	parameter int PAD_COUNT = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// report input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// pad, packet_number, buttons, left_trigger, right_trigger,
	// left_x, left_y, right_x, right_y, zero fill
	input  logic [gce_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// event output
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// event_pad, button_mask, value_first, value_second, zero fill
	output logic [gce_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// event_kind
	output logic [gce_pkg::KIND_W-1:0]     m_axis_tuser,
	// last event of a report
	output logic                           m_axis_tlast
);

	gce_pkg::cmd_t    cmd;
	gce_pkg::status_t status;

	// sequencer: idle -> check -> emit one event per free output slot
	gce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// report capture, per-pad state, pending event mask, output register
	gce_datapath #(
		.PAD_COUNT (PAD_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// a report transaction takes input ready low until the sequencer is back in idle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
	else $error("input ready right after a report transaction");

	// button events carry exactly one button bit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == gce_pkg::KIND_PRESS ||
			m_axis_tuser == gce_pkg::KIND_RELEASE) |-> $onehot(m_axis_tdata[17:2]))
	else $error("button event without a one-hot mask");

	// analog events carry no button bits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != gce_pkg::KIND_PRESS &&
			m_axis_tuser != gce_pkg::KIND_RELEASE |-> m_axis_tdata[17:2] == '0)
	else $error("analog event with a button mask");

	// an event not marked last is followed by more events, so no new report
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
	else $error("report accepted in the middle of an event run");

endmodule

// File: rtl/core/gce_ctrl.sv
// ----------------------------------------------------------------------------
// gce_ctrl
// sequencer: accept a report, check it against the stored one, emit events
// ----------------------------------------------------------------------------
module gce_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output gce_pkg::cmd_t    cmd,
	input  gce_pkg::status_t status
);

	gce_pkg::state_t state_q;
	gce_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gce_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gce_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = gce_pkg::ST_CHECK;
				end
			end
			gce_pkg::ST_CHECK: begin
				if (status.fresh && status.any_event) begin
					state_nxt = gce_pkg::ST_EMIT;
				end else begin
					state_nxt = gce_pkg::ST_IDLE;
				end
			end
			gce_pkg::ST_EMIT: begin
				if (status.out_free && status.final_event) begin
					state_nxt = gce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = gce_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.check   = 1'b0;
		cmd.emit    = 1'b0;
		case (state_q)
			gce_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			gce_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
			end
			gce_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/core/gce_datapath.sv
// ----------------------------------------------------------------------------
// gce_datapath
// report register, per-pad state, pending event mask and output register
// ----------------------------------------------------------------------------
module gce_datapath #(
	parameter int PAD_COUNT = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gce_pkg::cmd_t                     cmd,
	output gce_pkg::status_t                  status,
	input  logic [gce_pkg::IN_DATA_W-1:0]     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gce_pkg::OUT_DATA_W-1:0]    out_data,
	output logic [gce_pkg::KIND_W-1:0]        out_kind,
	output logic                              out_last
);

	localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam int BW    = gce_pkg::BUTTON_W;
	localparam int AW    = gce_pkg::AXIS_W;
	localparam int TW    = gce_pkg::TRIGGER_W;
	localparam int PW    = gce_pkg::PEND_W;

	// captured report
	logic [gce_pkg::PAD_W-1:0]    pad_q;
	logic [gce_pkg::PACKET_W-1:0] packet_q;
	logic [BW-1:0]                buttons_q;
	logic [2*TW-1:0]              triggers_q;
	logic [2*AW-1:0]              lstick_q;
	logic [2*AW-1:0]              rstick_q;

	gce_pkg::entry_t entry_q [PAD_COUNT];
	gce_pkg::entry_t old_entry;

	logic [IDX_W-1:0] idx;
	logic             pad_ok;
	logic [BW-1:0]    delta;
	logic [BW-1:0]    down;
	logic [BW-1:0]    up;
	logic [PW-1:0]    pend_new;
	logic [PW-1:0]    pend_q;
	logic [PW-1:0]    sel;
	logic [PW-1:0]    pend_rest;

	logic                         out_valid_q;
	logic [gce_pkg::KIND_W-1:0]   kind_nxt;
	logic [gce_pkg::KIND_W-1:0]   kind_q;
	logic [BW-1:0]                mask_nxt;
	logic [BW-1:0]                mask_q;
	logic [AW-1:0]                first_nxt;
	logic [AW-1:0]                first_q;
	logic [AW-1:0]                second_nxt;
	logic [AW-1:0]                second_q;
	logic                         last_q;
	logic [gce_pkg::PAD_W-1:0]    evpad_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pad_q      <= in_data[1:0];
			packet_q   <= in_data[33:2];
			buttons_q  <= in_data[49:34];
			triggers_q <= in_data[65:50];
			lstick_q   <= in_data[97:66];
			rstick_q   <= in_data[129:98];
		end
	end

	assign idx       = IDX_W'(pad_q);
	assign pad_ok    = 32'(pad_q) < PAD_COUNT;
	assign old_entry = entry_q[idx];

	assign delta = buttons_q ^ old_entry.buttons;
	assign down  = buttons_q & delta;
	assign up    = down ^ delta;

	always_comb begin
		pend_new = {(rstick_q != old_entry.right_stick),
			(lstick_q != old_entry.left_stick),
			(triggers_q[2*TW-1:TW] != old_entry.triggers[2*TW-1:TW]),
			(triggers_q[TW-1:0] != old_entry.triggers[TW-1:0]),
			up, down};
	end

	assign status.fresh     = pad_ok && (packet_q > old_entry.packet);
	assign status.any_event = |pend_new;

	// lowest pending event first
	assign sel       = pend_q & (~pend_q + PW'(1));
	assign pend_rest = pend_q & ~sel;
	assign status.final_event = ~|pend_rest;
	assign status.out_free    = !out_valid_q || out_ready;

	// per-pad state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAD_COUNT; i++) begin
				entry_q[i] <= '0;
			end
		end else if (cmd.check && status.fresh) begin
			entry_q[idx] <= '{packet: packet_q, buttons: buttons_q,
				triggers: triggers_q, left_stick: lstick_q, right_stick: rstick_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd.check) begin
			pend_q <= status.fresh ? pend_new : '0;
		end else if (cmd.emit) begin
			pend_q <= pend_rest;
		end
	end

	always_comb begin
		mask_nxt   = sel[BW-1:0] | sel[2*BW-1:BW];
		first_nxt  = '0;
		second_nxt = '0;
		if (|sel[BW-1:0]) begin
			kind_nxt = gce_pkg::KIND_PRESS;
		end else if (|sel[2*BW-1:BW]) begin
			kind_nxt = gce_pkg::KIND_RELEASE;
		end else if (sel[gce_pkg::PEND_LTRIG]) begin
			kind_nxt  = gce_pkg::KIND_LTRIG;
			first_nxt = AW'(triggers_q[TW-1:0]);
		end else if (sel[gce_pkg::PEND_RTRIG]) begin
			kind_nxt  = gce_pkg::KIND_RTRIG;
			first_nxt = AW'(triggers_q[2*TW-1:TW]);
		end else if (sel[gce_pkg::PEND_LSTK]) begin
			kind_nxt   = gce_pkg::KIND_LSTICK;
			first_nxt  = lstick_q[AW-1:0];
			second_nxt = lstick_q[2*AW-1:AW];
		end else begin
			kind_nxt   = gce_pkg::KIND_RSTICK;
			first_nxt  = rstick_q[AW-1:0];
			second_nxt = rstick_q[2*AW-1:AW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			evpad_q  <= pad_q;
			kind_q   <= kind_nxt;
			mask_q   <= mask_nxt;
			first_q  <= first_nxt;
			second_q <= second_nxt;
			last_q   <= status.final_event;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {6'b0, second_q, first_q, mask_q, evpad_q};
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule
